[design/edc_pkg.sv]
// shared types and constants of the exponential decay convolver
package edc_pkg;

  localparam int NUM_COMPONENTS = 3;
  localparam int MAX_POINTS     = 4096;
  localparam int QUEUE_DEPTH    = 4;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int LIMIT_CFG_W = 13;
  localparam int BIN_W       = 12;
  localparam int FIT_W       = 40;
  localparam int HPROD_W     = 32;
  localparam int OUT_W       = 48;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;

  localparam logic [COEF_W-1:0]      HALF_STEP_RESET   = 16'd4096;
  localparam logic [LIMIT_CFG_W-1:0] POINT_LIMIT_RESET = 13'd4096;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_AMPLITUDE_A = 3'd0,
    REG_DECAY_A     = 3'd1,
    REG_AMPLITUDE_B = 3'd2,
    REG_DECAY_B     = 3'd3,
    REG_AMPLITUDE_C = 3'd4,
    REG_DECAY_C     = 3'd5,
    REG_HALF_STEP   = 3'd6,
    REG_POINT_LIMIT = 3'd7
  } reg_idx_t;

  localparam reg_idx_t AMP_REG [3]   = '{REG_AMPLITUDE_A, REG_AMPLITUDE_B, REG_AMPLITUDE_C};
  localparam reg_idx_t DECAY_REG [3] = '{REG_DECAY_A, REG_DECAY_B, REG_DECAY_C};

  // one classified bin handed from front to back
  typedef struct packed {
    logic               compute;  // bin is inside the point limit
    logic               last;     // clear fits after this bin
    logic [BIN_W-1:0]   bin;
    logic [HPROD_W-1:0] hcur;     // h * current sample
    logic [HPROD_W-1:0] hprev;    // h * previous sample
  } item_t;

endpackage

[design/exponential_decay_convolver.sv]
// top level of the exponential decay convolver
//
// usage: instrument-response samples stream in on the in_ channel, one request per
// time bin, with in_tlast on the final bin of a curve. each bin inside the point
// limit yields one request on the out_ channel: the sum over the enabled decay
// components of amplitude times the trapezoidal recursive fit, in q.12, saturated.
// bins at or past the limit give nothing; the curve still ends at in_tlast.
// configuration goes through the cfg_ channel (index, data); the user writes it only while
// the block is idle, which the block itself does not enforce; cfg_ready is always high.
// a result passes the queue, the product, new-fit and weighted stages and the output register.
// the fit recursion loop in the back end takes a new bin only after the previous one has
// left its product stage (41x16 multiply, then round, add and saturate).
// a 4-entry queue sits between the front end (bin count, previous sample, h*x
// products, limit check) and the back end, so the input keeps accepting while
// the back end is busy or the receiver stalls; a stalled out_ request holds its data
// and the pipeline behind it fills, then the queue, then in_tready drops.
// reset (rst_n low, synchronous): amplitudes and decays 0, half_step 1.0,
// point_limit 4096, bin count, previous sample and fits cleared, no output pending.
module exponential_decay_convolver #(
  parameter int NUM_COMPONENTS = edc_pkg::NUM_COMPONENTS,
  parameter int MAX_POINTS     = edc_pkg::MAX_POINTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample input
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [edc_pkg::IN_TDATA_W-1:0]    in_tdata,   // [15:0] irf_sample
  input  logic                              in_tlast,   // last_sample
  // result output
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [edc_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [47:0] model_value, [59:48] bin_index
  output logic                              out_tlast,  // last_result
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [edc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [edc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic signed [edc_pkg::COEF_W-1:0]   amp_r [NUM_COMPONENTS];
  logic [edc_pkg::COEF_W-1:0]          decay_r [NUM_COMPONENTS];
  logic [edc_pkg::COEF_W-1:0]          half_step_r;
  logic [edc_pkg::LIMIT_CFG_W-1:0]     point_limit_r;
  logic                                cfg_write;

  logic           q_push, q_pop, q_full, q_not_empty;
  edc_pkg::item_t q_push_item, q_head;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // per-component amplitude and decay registers
  for (genvar k = 0; k < NUM_COMPONENTS; k++) begin : g_coef
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        amp_r[k]   <= '0;
        decay_r[k] <= '0;
      end else if (cfg_write) begin
        if (cfg_addr == edc_pkg::AMP_REG[k]) begin
          amp_r[k] <= cfg_data;
        end
        if (cfg_addr == edc_pkg::DECAY_REG[k]) begin
          decay_r[k] <= cfg_data;
        end
      end
    end
  end

  // shared step and limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_step_r   <= edc_pkg::HALF_STEP_RESET;
      point_limit_r <= edc_pkg::POINT_LIMIT_RESET;
    end else if (cfg_write) begin
      if (cfg_addr == edc_pkg::REG_HALF_STEP) begin
        half_step_r <= cfg_data;
      end
      if (cfg_addr == edc_pkg::REG_POINT_LIMIT) begin
        point_limit_r <= cfg_data[edc_pkg::LIMIT_CFG_W-1:0];
      end
    end
  end

  // front end: bin bookkeeping and classification
  edc_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .half_step   (half_step_r),
    .point_limit (point_limit_r),
    .q_full      (q_full),
    .push        (q_push),
    .push_item   (q_push_item)
  );

  // decoupling queue
  edc_queue #(
    .DEPTH (edc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // back end: fit recursion and weighted sum
  edc_back #(
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .amplitude   (amp_r),
    .decay       (decay_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

[design/edc_front.sv]
// front end: takes samples, tracks bin count and previous sample, classifies bins
module edc_front #(
  parameter int MAX_POINTS = edc_pkg::MAX_POINTS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [edc_pkg::IN_TDATA_W-1:0]     in_tdata,   // irf_sample
  input  logic                               in_tlast,   // last_sample
  input  logic [edc_pkg::COEF_W-1:0]         half_step,
  input  logic [edc_pkg::LIMIT_CFG_W-1:0]    point_limit,
  input  logic                               q_full,
  output logic                               push,
  output edc_pkg::item_t                     push_item
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int LIM_W = (CNT_W > edc_pkg::LIMIT_CFG_W) ? CNT_W : edc_pkg::LIMIT_CFG_W;
  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  logic [CNT_W-1:0]             bin_r, bin_nxt;
  logic [edc_pkg::SAMPLE_W-1:0] prev_r, prev_nxt;
  logic [LIM_W-1:0]             limit;
  logic [LIM_W-1:0]             bin_ext;
  logic                         in_range;
  logic                         accept;

  assign limit    = (LIM_W'(point_limit) < MAX_LIM) ? LIM_W'(point_limit) : MAX_LIM;
  assign bin_ext  = LIM_W'(bin_r);
  assign in_range = bin_ext < limit;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  // bins past the limit only matter if they end the curve
  assign push      = accept && (in_range || in_tlast);

  always_comb begin
    push_item.compute = in_range;
    push_item.last    = in_tlast;
    push_item.bin     = bin_ext[edc_pkg::BIN_W-1:0];
    push_item.hcur    = edc_pkg::HPROD_W'(half_step) *
                        edc_pkg::HPROD_W'(in_tdata[edc_pkg::SAMPLE_W-1:0]);
    push_item.hprev   = edc_pkg::HPROD_W'(half_step) * edc_pkg::HPROD_W'(prev_r);
  end

  always_comb begin
    bin_nxt  = bin_r;
    prev_nxt = prev_r;
    if (accept) begin
      if (in_tlast) begin
        bin_nxt  = '0;
        prev_nxt = '0;
      end else begin
        if (bin_r < MAX_CNT) begin
          bin_nxt = bin_r + CNT_W'(1);
        end
        if (in_range) begin
          prev_nxt = in_tdata[edc_pkg::SAMPLE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r  <= '0;
      prev_r <= '0;
    end else begin
      bin_r  <= bin_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

[design/edc_queue.sv]
// short fifo between front and back
module edc_queue #(
  parameter int DEPTH = edc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  edc_pkg::item_t push_item,
  input  logic           pop,
  output edc_pkg::item_t head,
  output logic           full,
  output logic           not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  edc_pkg::item_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = count_r == CNT_W'(DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[design/edc_back.sv]
// back end: per-component fit recursion, amplitude weighting, sum and output register
module edc_back #(
  parameter int NUM_COMPONENTS = edc_pkg::NUM_COMPONENTS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [edc_pkg::COEF_W-1:0]  amplitude [NUM_COMPONENTS],
  input  logic [edc_pkg::COEF_W-1:0]         decay [NUM_COMPONENTS],
  input  logic                               q_not_empty,
  input  edc_pkg::item_t                     q_head,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [edc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast
);

  localparam int FIT_W  = edc_pkg::FIT_W;
  localparam int ADD_W  = FIT_W + 1;
  localparam int MUL_W  = ADD_W + edc_pkg::COEF_W;
  localparam int RND_W  = MUL_W - 16;
  localparam int WP_W   = ADD_W + edc_pkg::COEF_W;
  localparam int SUM_W  = WP_W + 2;
  localparam int OUT_W  = edc_pkg::OUT_W;
  localparam int BIN_W  = edc_pkg::BIN_W;
  localparam int PAD_W  = edc_pkg::OUT_TDATA_W - OUT_W - BIN_W;
  localparam logic [MUL_W-1:0]          RND_HALF = MUL_W'(32768);
  localparam logic [FIT_W:0]            FIT_MAX  = {1'b0, {FIT_W{1'b1}}};
  localparam logic signed [SUM_W-1:0]   Q12_HALF = SUM_W'(2048);
  localparam logic signed [SUM_W-1:0]   OUT_HI   = {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]   OUT_LO   = {{(SUM_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  // fit state
  logic [FIT_W-1:0] fit_r [NUM_COMPONENTS];

  // product stage
  logic                        p_valid_r, p_compute_r, p_last_r;
  logic [BIN_W-1:0]            p_bin_r;
  logic [edc_pkg::HPROD_W-1:0] p_hcur_r;
  logic [MUL_W-1:0]            p_prod_r [NUM_COMPONENTS];

  // new fit stage
  logic             f_valid_r, f_last_r;
  logic [BIN_W-1:0] f_bin_r;
  logic [FIT_W-1:0] f_fit_r [NUM_COMPONENTS];

  // weighted stage
  logic                    m_valid_r, m_last_r;
  logic [BIN_W-1:0]        m_bin_r;
  logic signed [WP_W-1:0]  m_prod_r [NUM_COMPONENTS];

  // output register
  logic             out_valid_r, out_last_r;
  logic [BIN_W-1:0] out_bin_r;
  logic [OUT_W-1:0] out_value_r, out_value_nxt;

  logic out_free, m_free, f_free, p_fire, f_adv, m_adv;
  logic [FIT_W-1:0]        fit_new [NUM_COMPONENTS];
  logic signed [SUM_W-1:0] acc, biased, rounded;

  assign out_free = !out_valid_r || out_tready;
  assign m_free   = !m_valid_r || out_free;
  assign f_free   = !f_valid_r || m_free;
  assign m_adv    = m_valid_r && out_free;
  assign f_adv    = f_valid_r && m_free;
  // the fit loop takes a new bin only when the product stage is empty: multiply, then round-add-saturate
  assign q_pop    = q_not_empty && !p_valid_r;
  assign p_fire   = p_valid_r && (!p_compute_r || f_free);

  for (genvar k = 0; k < NUM_COMPONENTS; k++) begin : g_lane
    logic [ADD_W-1:0] fit_sum;
    logic [MUL_W-1:0] rnd_sum;
    logic [RND_W-1:0] rnd;
    logic [FIT_W:0]   fit_add;

    assign fit_sum = {1'b0, fit_r[k]} + ADD_W'(q_head.hprev);
    assign rnd_sum = p_prod_r[k] + RND_HALF;
    assign rnd     = rnd_sum[MUL_W-1:16];
    assign fit_add = (FIT_W+1)'(rnd) + (FIT_W+1)'(p_hcur_r);
    assign fit_new[k] = (fit_add > FIT_MAX) ? FIT_MAX[FIT_W-1:0] : fit_add[FIT_W-1:0];

    always_ff @(posedge clk) begin
      if (q_pop) begin
        p_prod_r[k] <= MUL_W'(fit_sum) * MUL_W'(decay[k]);
      end
      if (p_fire && p_compute_r) begin
        f_fit_r[k] <= fit_new[k];
      end
      if (f_adv) begin
        m_prod_r[k] <= amplitude[k] * $signed({1'b0, f_fit_r[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fit_r[k] <= '0;
      end else if (p_fire) begin
        if (p_last_r) begin
          fit_r[k] <= '0;
        end else if (p_compute_r) begin
          fit_r[k] <= fit_new[k];
        end
      end
    end
  end

  // sum, round half up to q.12, saturate
  always_comb begin
    acc = '0;
    for (int k = 0; k < NUM_COMPONENTS; k++) begin
      acc = acc + {{(SUM_W-WP_W){m_prod_r[k][WP_W-1]}}, m_prod_r[k]};
    end
    biased  = acc + Q12_HALF;
    rounded = biased >>> 12;
    if (rounded > OUT_HI) begin
      out_value_nxt = OUT_HI[OUT_W-1:0];
    end else if (rounded < OUT_LO) begin
      out_value_nxt = OUT_LO[OUT_W-1:0];
    end else begin
      out_value_nxt = rounded[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_compute_r <= q_head.compute;
      p_last_r    <= q_head.last;
      p_bin_r     <= q_head.bin;
      p_hcur_r    <= q_head.hcur;
    end
    if (p_fire && p_compute_r) begin
      f_last_r <= p_last_r;
      f_bin_r  <= p_bin_r;
    end
    if (f_adv) begin
      m_last_r <= f_last_r;
      m_bin_r  <= f_bin_r;
    end
    if (m_adv) begin
      out_value_r <= out_value_nxt;
      out_bin_r   <= m_bin_r;
      out_last_r  <= m_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      f_valid_r   <= 1'b0;
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        p_valid_r <= 1'b1;
      end else if (p_fire) begin
        p_valid_r <= 1'b0;
      end
      if (p_fire && p_compute_r) begin
        f_valid_r <= 1'b1;
      end else if (f_adv) begin
        f_valid_r <= 1'b0;
      end
      if (f_adv) begin
        m_valid_r <= 1'b1;
      end else if (m_adv) begin
        m_valid_r <= 1'b0;
      end
      if (m_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_bin_r, out_value_r};
  assign out_tlast  = out_last_r;

endmodule

[design/edc_checker.sv]
// port-level checker for the exponential decay convolver, bound to the top level
module edc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [edc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                              out_tlast
);

  logic last_seen_r;

  // remembers whether the previous delivered result closed a curve
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seen_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      last_seen_r <= out_tlast;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:60] == 4'd0)
    else $error("tdata pad bits not zero");

  a_curve_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && last_seen_r |-> out_tdata[59:48] == 12'd0)
    else $error("new curve did not start at bin zero");

endmodule

bind exponential_decay_convolver edc_checker u_edc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[bench/decay_fit_checker.sv]
// checker that predicts the convolver's results and compares them with the output stream
`timescale 1ns / 100ps
module decay_fit_checker
  import edc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     error_count,
  output int                     pending_count,
  output int                     bins_checked
);

  localparam longint unsigned FIT_CEIL  = (64'd1 << FIT_W) - 64'd1;
  localparam longint          VALUE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint          VALUE_MIN = -VALUE_MAX - 64'sd1;
  localparam int              MAX_PRINT = 40;

  typedef struct {
    logic [OUT_W-1:0] value;
    logic [BIN_W-1:0] bin_no;
    logic             last;
  } bin_result_t;

  bin_result_t expected_bins [$];

  logic signed [COEF_W-1:0]      amplitude [3];
  logic [COEF_W-1:0]             decay [3];
  logic [COEF_W-1:0]             half_step;
  logic [LIMIT_CFG_W-1:0]        point_limit;
  logic [LIMIT_CFG_W-1:0]        bin_count;
  logic [SAMPLE_W-1:0]           prev_irf;
  logic [FIT_W-1:0]              fit [3];

  initial begin
    error_count   = 0;
    pending_count = 0;
    bins_checked  = 0;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINT) $display("%0t: mismatch, %s", $time, msg);
  endtask

  task automatic clear_curve();
    bin_count = '0;
    prev_irf  = '0;
    for (int k = 0; k < 3; k++) fit[k] = '0;
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_AMPLITUDE_A: amplitude[0] = value;
      REG_DECAY_A:     decay[0] = value;
      REG_AMPLITUDE_B: amplitude[1] = value;
      REG_DECAY_B:     decay[1] = value;
      REG_AMPLITUDE_C: amplitude[2] = value;
      REG_DECAY_C:     decay[2] = value;
      REG_HALF_STEP:   half_step = value;
      REG_POINT_LIMIT: point_limit = value[LIMIT_CFG_W-1:0];
      default: ;
    endcase
  endtask

  // one bin through the trapezoidal recursion of every component
  task automatic predict_bin(input logic [SAMPLE_W-1:0] irf, input logic last_bin);
    longint unsigned span, h_prev, h_cur, next_fit;
    longint          fit_sum, rounded;
    bin_result_t     want;
    span = (point_limit < MAX_POINTS) ? point_limit : MAX_POINTS;
    if (bin_count < span) begin
      h_prev  = 64'(half_step) * 64'(prev_irf);
      h_cur   = 64'(half_step) * 64'(irf);
      fit_sum = 0;
      for (int k = 0; k < 3; k++) begin
        // (fit + h*prev)*e rounded half up back to q.12, then + h*cur
        next_fit = (((64'(fit[k]) + h_prev) * 64'(decay[k])) + 64'd32768) >> 16;
        next_fit = next_fit + h_cur;
        if (next_fit > FIT_CEIL) next_fit = FIT_CEIL;
        fit[k] = next_fit[FIT_W-1:0];
        if (k < NUM_COMPONENTS) fit_sum += longint'(amplitude[k]) * longint'(next_fit);
      end
      // q.24 down to q.12, half toward plus infinity
      rounded = (fit_sum + 64'sd2048) >>> 12;
      if (rounded > VALUE_MAX) rounded = VALUE_MAX;
      if (rounded < VALUE_MIN) rounded = VALUE_MIN;
      want.value  = rounded[OUT_W-1:0];
      want.bin_no = bin_count[BIN_W-1:0];
      want.last   = last_bin;
      expected_bins.push_back(want);
      prev_irf = irf;
    end
    if (bin_count < MAX_POINTS) bin_count++;
    if (last_bin) clear_curve();
  endtask

  task automatic check_result();
    bin_result_t      want;
    logic [OUT_W-1:0] got_value;
    logic [BIN_W-1:0] got_bin;
    got_value = out_tdata[OUT_W-1:0];
    got_bin   = out_tdata[OUT_W +: BIN_W];
    if (expected_bins.size() == 0) begin
      report_mismatch($sformatf("result for bin %0d with none pending", got_bin));
      return;
    end
    want = expected_bins.pop_front();
    bins_checked++;
    if (got_value !== want.value)
      report_mismatch($sformatf("bin %0d model_value %h, want %h",
                                want.bin_no, got_value, want.value));
    if (got_bin !== want.bin_no)
      report_mismatch($sformatf("bin_index %0d, want %0d", got_bin, want.bin_no));
    if (out_tlast !== want.last)
      report_mismatch($sformatf("bin %0d last_result %b, want %b",
                                want.bin_no, out_tlast, want.last));
    if (out_tdata[OUT_TDATA_W-1:OUT_W+BIN_W] !== '0)
      report_mismatch($sformatf("bin %0d padding bits %h not zero",
                                want.bin_no, out_tdata[OUT_TDATA_W-1:OUT_W+BIN_W]));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        amplitude[k] = '0;
        decay[k]     = '0;
      end
      half_step   = HALF_STEP_RESET;
      point_limit = POINT_LIMIT_RESET;
      clear_curve();
      expected_bins.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_register(reg_idx_t'(cfg_addr), cfg_data);
      // a result never leaves before its request has passed the queue and the back-end registers, so check first
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) predict_bin(in_tdata[SAMPLE_W-1:0], in_tlast);
    end
    pending_count = expected_bins.size();
  end

endmodule

[bench/tb_exponential_decay_convolver.sv]
// testbench top for the exponential decay convolver: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_exponential_decay_convolver;
  import edc_pkg::*;

  // cycles let pass after the last expected result before a register write or the
  // verdict: bins past the limit give nothing but may still sit in the queue
  localparam int SETTLE_CYCLES   = 32;
  localparam int RANDOM_ITEMS    = 450;
  localparam int PHASES          = 9;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [15:0] irf_sample
  logic                   in_tlast;   // last_sample
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [47:0] model_value, [59:48] bin_index
  logic                   out_tlast;  // last_result
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // idle rates in percent of cycles, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit high_irf      = 1'b0;

  int samples_sent  = 0;
  int curves_sent   = 0;
  int settings_used = 0;

  int error_count;
  int pending_count;
  int bins_checked;

  always #10 clk = ~clk;

  exponential_decay_convolver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  decay_fit_checker fit_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count),
    .bins_checked  (bins_checked)
  );

  // receiver: stalls at random, one decision per cycle on the falling edge
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // coefficient values, biased toward the extremes: zero, all ones, signed min and max
  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // point limits: short ones so curves run past them, the reset value, one below it, the
  // 13-bit maximum that is clipped to the maximum curve length, and random ones in between
  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'($urandom_range(30, 1));
      4, 5:       return 16'd4096;
      6:          return 16'd8191;
      7:          return 16'd4095;
      default:    return 16'($urandom_range(8191, 31));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_irf();
    if (high_irf) begin
      if ($urandom_range(3) == 0) return 16'hFFFF;
      return 16'($urandom_range(65535, 49152));
    end
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly short curves, now and then one that runs past a short limit
  function automatic int pick_len();
    if ($urandom_range(4) == 0) return $urandom_range(80, 13);
    return $urandom_range(12, 1);
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // let every expected result out, then the silent bins still in flight
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [COEF_W-1:0] amp_a, dec_a, amp_b, dec_b,
                            input logic [COEF_W-1:0] amp_c, dec_c, h_half,
                            input logic [CFG_DATA_W-1:0] limit);
    drain();
    write_reg(REG_AMPLITUDE_A, amp_a);
    write_reg(REG_DECAY_A, dec_a);
    write_reg(REG_AMPLITUDE_B, amp_b);
    write_reg(REG_DECAY_B, dec_b);
    write_reg(REG_AMPLITUDE_C, amp_c);
    write_reg(REG_DECAY_C, dec_c);
    write_reg(REG_HALF_STEP, h_half);
    write_reg(REG_POINT_LIMIT, limit);
    settings_used++;
  endtask

  task automatic random_config(input logic [CFG_DATA_W-1:0] limit);
    set_config(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
               pick_coef(), pick_coef(), pick_coef(), limit);
  endtask

  // one sample request; valid stays high into the next request when no gap is drawn
  task automatic send_irf(input logic [SAMPLE_W-1:0] irf, input logic last_bin);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= irf;
    in_tlast  <= last_bin;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  task automatic send_curve(input int len);
    for (int i = 0; i < len; i++) send_irf(pick_irf(), i == len - 1);
    curves_sent++;
  endtask

  initial begin
    int target;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr  = REG_AMPLITUDE_A;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: every amplitude zero, so every component is disabled
    send_irf(16'd1234, 1'b0);
    send_irf(16'hFFFF, 1'b1);
    curves_sent++;

    // signed amplitude extremes, decay of one, of zero and of one half
    set_config(16'h7FFF, 16'hFFFF, 16'h8000, 16'h0000, 16'h0001, 16'h8000,
               HALF_STEP_RESET, 16'd4096);
    send_irf(16'h0000, 1'b0);
    send_irf(16'hFFFF, 1'b0);
    send_irf(16'hFFFF, 1'b0);
    send_irf(16'h0001, 1'b0);
    send_irf(16'h5555, 1'b0);
    send_irf(16'hAAAA, 1'b1);
    // a new curve starts at full scale with the previous sample taken as zero
    send_irf(16'hFFFF, 1'b1);
    curves_sent += 2;

    // short limit: two silent bins, the last of them still clears the curve
    set_config(16'h1000, 16'hF000, 16'hF000, 16'h8000, 16'h0000, 16'hFFFF,
               16'hFFFF, 16'd3);
    send_irf(16'h8000, 1'b0);
    send_irf(16'h7FFF, 1'b0);
    send_irf(16'hFFFF, 1'b0);
    send_irf(16'h0001, 1'b0);
    send_irf(16'h1234, 1'b1);
    send_irf(16'h00FF, 1'b0);
    send_irf(16'hFF00, 1'b1);
    curves_sent += 2;

    // zero limit: no result at all
    set_config(16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF,
               16'hFFFF, 16'd0);
    send_irf(16'hFFFF, 1'b0);
    send_irf(16'hFFFF, 1'b1);
    curves_sent++;

    // zero half step with the widest limit: fits stay zero
    set_config(16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
               16'h0000, 16'd8191);
    send_irf(16'hFFFF, 1'b0);
    send_irf(16'h0000, 1'b0);
    send_irf(16'hFFFF, 1'b1);
    curves_sent++;

    // random curves: three phases per idling mode, the middle one of the second
    // mode drives the fits into saturation with full-scale gains and samples
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase / 3)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      high_irf = (phase == 4);
      if (high_irf)
        set_config(16'h7FFF, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h7FFF, 16'hFFFF,
                   16'hFFFF, 16'd8191);
      else
        random_config(pick_limit());
      target = samples_sent + RANDOM_ITEMS / PHASES;
      while (samples_sent < target)
        send_curve(high_irf ? $urandom_range(260, 160) : pick_len());
    end

    drain();
    $display("sent %0d samples in %0d curves under %0d register settings",
             samples_sent, curves_sent, settings_used);
    $display("checked %0d results, %0d mismatches", bins_checked, error_count);
    if (error_count == 0 && pending_count == 0)
      $display("** exponential_decay_convolver: PASSED **");
    else
      $display("** exponential_decay_convolver: FAILED **");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #(5_000_000);
    $display("timeout with %0d results still pending", pending_count);
    $display("** exponential_decay_convolver: FAILED **");
    $finish;
  end

endmodule
